[rtl/sphb_pkg.sv]
// Shared widths, register indexes and constants of the string hash bucket block
`default_nettype none
package sphb_pkg;
    localparam int CHAR_W   = 8;
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int MULT_W   = 6;

    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [HASH_W-1:0]     hash_t;
    typedef logic [BUCKET_W-1:0]   bucket_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [MULT_W-1:0]     mult_t;

    localparam cfg_idx_t REG_TABLE_SIZE   = 2'd0;
    localparam cfg_idx_t REG_HASH_VARIANT = 2'd1;

    localparam mult_t   MULT_PRIMARY       = 6'd31;
    localparam mult_t   MULT_SECONDARY     = 6'd61;
    localparam bucket_t TABLE_SIZE_RESET   = 31'd1024;
    localparam char_t   CHAR_TERMINATOR    = 8'd0;
endpackage
`default_nettype wire

[rtl/sphb_char_if.sv]
// Valid/ready channel interfaces for name characters and bucket indexes
`default_nettype none
interface sphb_char_if;
    logic                 valid;
    logic                 ready;
    sphb_pkg::char_t      char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface sphb_bucket_if;
    logic                 valid;
    logic                 ready;
    sphb_pkg::bucket_t    bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface
`default_nettype wire

[rtl/string_polynomial_hash_bucket_top.sv]
// Polynomial string hash with bit-serial modulo reduction to a bucket index
//
//  channel     dir  handshake       payload
//  char_in     in   valid/ready     char_byte     [7:0]
//  bucket_out  out  valid/ready     bucket_index  [30:0]
//  cfg         in   cfg_we          cfg_index [1:0], cfg_wdata [30:0]
//
//  Non-zero characters: one per cycle while idle, each folded into the running hash.
//  Terminator: restoring division over the 32 hash bits, one quotient bit a cycle,
//  then a fold step turns the remainder into the bucket; no new character until then.
//  A held result stalls the fold step, and char_in stays not ready until it leaves.
//  Reset clears the running hash and restores table_size 1024, multiplier 31.
`default_nettype none
module string_polynomial_hash_bucket_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sphb_char_if.sink                  char_in,
    sphb_bucket_if.source              bucket_out,
    input  wire logic                  cfg_we,
    input  wire sphb_pkg::cfg_idx_t    cfg_index,
    input  wire sphb_pkg::cfg_data_t   cfg_wdata
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;
    localparam int CNT_W = $clog2(sphb_pkg::HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sphb_pkg::HASH_W - 1);

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    sphb_pkg::hash_t       hash_reg, hash_next;
    sphb_pkg::hash_t       mag_reg, mag_next;
    sphb_pkg::bucket_t     rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    sphb_pkg::bucket_t     table_size_reg;
    logic                  variant_reg;
    logic                  out_valid_reg, out_valid_next;
    sphb_pkg::bucket_t     bucket_reg, bucket_next;

    logic                  in_fire;
    sphb_pkg::mult_t       mult;
    sphb_pkg::hash_t       ext;
    sphb_pkg::hash_t       product;
    logic [sphb_pkg::BUCKET_W:0] trial;
    logic [sphb_pkg::BUCKET_W:0] divisor;
    sphb_pkg::bucket_t     folded;

    assign char_in.ready       = (state_reg == ST_IDLE);
    assign in_fire             = char_in.valid && char_in.ready;
    assign bucket_out.valid    = out_valid_reg;
    assign bucket_out.bucket_index = bucket_reg;

    assign mult    = variant_reg ? sphb_pkg::MULT_SECONDARY : sphb_pkg::MULT_PRIMARY;
    assign ext     = {{(sphb_pkg::HASH_W-sphb_pkg::CHAR_W){char_in.char_byte[sphb_pkg::CHAR_W-1]}},
                      char_in.char_byte};
    assign product = sphb_pkg::HASH_W'(hash_reg * mult);
    assign trial   = {rem_reg, mag_reg[sphb_pkg::HASH_W-1]};
    assign divisor = {1'b0, table_size_reg};
    assign folded  = (table_size_reg == '0) ? '0 :
                     (neg_reg && rem_reg != '0) ? table_size_reg - rem_reg : rem_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !bucket_out.ready;
        bucket_next    = bucket_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (char_in.char_byte == sphb_pkg::CHAR_TERMINATOR)
                    begin
                        neg_next   = hash_reg[sphb_pkg::HASH_W-1];
                        mag_next   = hash_reg[sphb_pkg::HASH_W-1] ? (~hash_reg) + 1'b1 : hash_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        hash_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        hash_next = product + ext;
                    end
                end
            end
            ST_DIV:
            begin
                if (trial >= divisor)
                begin
                    rem_next = sphb_pkg::BUCKET_W'(trial - divisor);
                end
                else
                begin
                    rem_next = sphb_pkg::BUCKET_W'(trial);
                end
                mag_next = {mag_reg[sphb_pkg::HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (!out_valid_reg || bucket_out.ready)
                begin
                    out_valid_next = 1'b1;
                    bucket_next    = folded;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            hash_reg       <= '0;
            table_size_reg <= sphb_pkg::TABLE_SIZE_RESET;
            variant_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == sphb_pkg::REG_TABLE_SIZE)
            begin
                table_size_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == sphb_pkg::REG_HASH_VARIANT)
            begin
                variant_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        bucket_reg <= bucket_next;
    end
endmodule
`default_nettype wire

[rtl/sphb_checker.sv]
// Port-level assertions for the string hash bucket block and their bind
`default_nettype none
module sphb_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire sphb_pkg::char_t       char_byte,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire sphb_pkg::bucket_t     bucket_index,
    input wire logic                  cfg_we,
    input wire sphb_pkg::cfg_idx_t    cfg_index,
    input wire sphb_pkg::cfg_data_t   cfg_wdata
);
    sphb_pkg::bucket_t table_size_reg;
    logic              term_fire;

    assign term_fire = in_valid && in_ready && (char_byte == sphb_pkg::CHAR_TERMINATOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= sphb_pkg::TABLE_SIZE_RESET;
        end
        else if (cfg_we && cfg_index == sphb_pkg::REG_TABLE_SIZE)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    // hold the input while the reduction runs
    assert property (@(posedge clk) disable iff (!rst_n)
        term_fire |=> !in_ready)
        else $error("character accepted right after a terminator");

    assert property (@(posedge clk) disable iff (!rst_n)
        term_fire |-> ##33 !in_ready)
        else $error("reduction finished too early");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_size_reg != '0) |-> (bucket_index < table_size_reg))
        else $error("bucket index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(bucket_index)))
        else $error("held result changed");
endmodule

bind string_polynomial_hash_bucket_top sphb_checker u_sphb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (char_in.valid),
    .in_ready     (char_in.ready),
    .char_byte    (char_in.char_byte),
    .out_valid    (bucket_out.valid),
    .out_ready    (bucket_out.ready),
    .bucket_index (bucket_out.bucket_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
);
`default_nettype wire

[bench/tb_string_polynomial_hash_bucket_top.sv]
// Self-checking testbench for the polynomial string hash bucket block
`default_nettype none
module tb_string_polynomial_hash_bucket_top;
    import sphb_pkg::*;

    localparam int       ITEM_TARGET    = 1550;
    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       SETTLE_CYCLES  = 8;
    localparam int       DRAIN_CYCLES   = 40;
    localparam int       REPORT_MAX     = 10;
    localparam cfg_idx_t REG_SPARE_2    = 2'd2;
    localparam cfg_idx_t REG_SPARE_3    = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_wdata;

    sphb_char_if   char_ch ();
    sphb_bucket_if bucket_ch ();

    string_polynomial_hash_bucket_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .bucket_out (bucket_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    hash_t   name_hash;
    bucket_t table_buckets;
    logic    use_secondary;
    bucket_t pending_buckets[$];

    int chars_sent;
    int names_sent;
    int buckets_checked;
    int reg_writes;
    int mismatches;
    int burst_left;
    int stall_left;
    int quiet_cycles;
    logic stall_hold;

    always #5 clk = ~clk;

    function automatic bucket_t bucket_of_hash(input hash_t h, input bucket_t n);
        logic [31:0] mag;
        logic [31:0] rem;
        if (n == '0)
            return '0;
        if (!h[31])
            return bucket_t'(h % {1'b0, n});
        mag = ~h + 32'd1;
        rem = mag % {1'b0, n};
        return (rem == '0) ? '0 : bucket_t'({1'b0, n} - rem);
    endfunction

    function automatic void note_mismatch(input string what, input bucket_t want,
                                          input bucket_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("Mismatch (%s) at %0t: expected bucket %0d, got %0d",
                     what, $time, want, got);
    endfunction

    // hold a random stall pattern on the result side
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_hold = ($urandom_range(0, 2) == 0);
            stall_left = stall_hold ? $urandom_range(1, 20) : $urandom_range(1, 40);
            bucket_ch.ready <= !stall_hold;
        end
        stall_left--;
    end

    always @(posedge clk)
    begin : check_buckets
        bucket_t want;
        if (rst_n && bucket_ch.valid && bucket_ch.ready)
        begin
            if (pending_buckets.size() == 0)
                note_mismatch("unexpected item", '0, bucket_ch.bucket_index);
            else
            begin
                want = pending_buckets.pop_front();
                if (bucket_ch.bucket_index !== want)
                    note_mismatch("bucket_index", want, bucket_ch.bucket_index);
                buckets_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (bucket_ch.valid && bucket_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("No handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_char(input char_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_byte <= c;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        if (c == CHAR_TERMINATOR)
        begin
            pending_buckets.push_back(bucket_of_hash(name_hash, table_buckets));
            name_hash = '0;
            names_sent++;
        end
        else
            name_hash = hash_t'(name_hash * hash_t'(use_secondary ? MULT_SECONDARY
                                                                   : MULT_PRIMARY)
                                + {{24{c[7]}}, c});
        chars_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // build a name whose hash equals target, digits in bijective base of the multiplier
    task automatic send_name_for_hash(input hash_t target);
        char_t           digits[$];
        longint unsigned rest;
        longint unsigned radix;
        longint unsigned digit;
        radix = use_secondary ? MULT_SECONDARY : MULT_PRIMARY;
        rest  = target;
        while (rest != 0)
        begin
            digit = rest % radix;
            if (digit == 0)
                digit = radix;
            digits.push_front(char_t'(digit));
            rest = (rest - digit) / radix;
        end
        foreach (digits[i])
            send_char(digits[i]);
        send_char(CHAR_TERMINATOR);
    endtask

    task automatic wait_for_idle();
        char_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_buckets.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_TABLE_SIZE)
            table_buckets = bucket_t'(data);
        else if (idx == REG_HASH_VARIANT)
            use_secondary = data[0];
        reg_writes++;
    endtask

    task automatic test_reset_defaults();
        send_char(CHAR_TERMINATOR);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h01);
        send_char(CHAR_TERMINATOR);
    endtask

    task automatic test_most_negative_hash();
        wait_for_idle();
        write_reg(REG_TABLE_SIZE, 31'd3);
        send_name_for_hash(32'h8000_0000);
        wait_for_idle();
        write_reg(REG_HASH_VARIANT, 31'd1);
        write_reg(REG_TABLE_SIZE, TABLE_SIZE_RESET);
        send_name_for_hash(32'h8000_0000);
    endtask

    task automatic test_zero_table_size();
        wait_for_idle();
        write_reg(REG_TABLE_SIZE, '0);
        write_reg(REG_HASH_VARIANT, 31'h7FFF_FFFF);
        send_char(8'hFF);
        send_char(CHAR_TERMINATOR);
    endtask

    task automatic test_register_masking();
        wait_for_idle();
        write_reg(REG_SPARE_2, 31'h7FFF_FFFF);
        write_reg(REG_SPARE_3, 31'h7FFF_FFFF);
        write_reg(REG_HASH_VARIANT, 31'd2);
        write_reg(REG_TABLE_SIZE, 31'h7FFF_FFFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(CHAR_TERMINATOR);
    endtask

    task automatic test_random_names();
        int pick;
        int len;
        int names_in_phase;
        cfg_data_t size_val;
        while (chars_sent < ITEM_TARGET)
        begin
            wait_for_idle();
            case ($urandom_range(0, 9))
                0: size_val = 31'd1;
                1: size_val = 31'd2;
                2: size_val = TABLE_SIZE_RESET;
                3: size_val = 31'h7FFF_FFFF;
                4: size_val = '0;
                5: size_val = cfg_data_t'($urandom_range(3, 64));
                6: size_val = cfg_data_t'(1) << $urandom_range(0, 30);
                default: size_val = cfg_data_t'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          cfg_data_t'($urandom));
            write_reg(REG_TABLE_SIZE, size_val);
            write_reg(REG_HASH_VARIANT, cfg_data_t'($urandom));
            names_in_phase = $urandom_range(8, 30);
            repeat (names_in_phase)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_name_for_hash(hash_t'($urandom));
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        len = $urandom_range(0, 10);
                    else if (pick < 19)
                        len = $urandom_range(11, 24);
                    else
                        len = $urandom_range(25, 60);
                    repeat (len)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 5)
                            send_char(char_t'($urandom_range(32, 126)));
                        else if (pick < 9)
                            send_char(char_t'($urandom_range(1, 255)));
                        else
                            case ($urandom_range(0, 3))
                                0: send_char(8'h01);
                                1: send_char(8'h7F);
                                2: send_char(8'h80);
                                default: send_char(8'hFF);
                            endcase
                    end
                    send_char(CHAR_TERMINATOR);
                end
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        char_ch.valid     = 1'b0;
        char_ch.char_byte = '0;
        bucket_ch.ready   = 1'b0;
        name_hash         = '0;
        table_buckets     = TABLE_SIZE_RESET;
        use_secondary     = 1'b0;
        chars_sent        = 0;
        names_sent        = 0;
        buckets_checked   = 0;
        reg_writes        = 0;
        mismatches        = 0;
        burst_left        = 0;
        stall_left        = 0;
        quiet_cycles      = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_most_negative_hash();
        test_zero_table_size();
        test_register_masking();
        test_random_names();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_buckets.size();
        $display("Sent %0d characters forming %0d names; checked %0d bucket indexes",
                 chars_sent, names_sent, buckets_checked);
        $display("Applied %0d register writes across both multipliers; %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
